// ===== rtl/core/lcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcbs_pkg - shared types and constants for the LBA to CHS burst sequencer
// Controller states, the command and status bundles between the controller
// and the datapath, register indexes and geometry reset values.
// ----------------------------------------------------------------------------
package lcbs_pkg;

    // field widths
    localparam int LBA_W   = 32;
    localparam int COUNT_W = 7;
    localparam int CYL_W   = 10;
    localparam int HEAD_W  = 8;
    localparam int SECT_W  = 6;
    localparam int DRIVE_W = 8;
    localparam int CFG_W   = 10;
    localparam int IDX_W   = 2;

    // divider: two quotient bits per cycle over a 32-bit dividend
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS         = LBA_W / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);
    localparam int DIV_W             = 8;

    // geometry after reset
    localparam logic [SECT_W-1:0]  SPT_RESET   = 6'd18;
    localparam logic [HEAD_W-1:0]  HPC_RESET   = 8'd2;
    localparam logic [CYL_W-1:0]   LCYL_RESET  = 10'd79;
    localparam logic [DRIVE_W-1:0] DRIVE_RESET = 8'd0;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SECTORS_PER_TRACK  = 2'd0,
        REG_HEADS_PER_CYLINDER = 2'd1,
        REG_LAST_CYLINDER      = 2'd2,
        REG_DRIVE_NUMBER       = 2'd3
    } cfg_index_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT_SECT,
        ST_WAIT_HEAD,
        ST_EMIT,
        ST_OOR
    } lcbs_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;     // capture start block and count
        logic div_start;   // launch a division
        logic div_sel;     // 0: start / sectors, 1: quotient / heads
        logic latch_sect;  // take the sector from the first remainder
        logic latch_chs;   // take cylinder and head, arm the run
        logic emit;        // push current position and step on
        logic emit_oor;    // push the flagged out of range word
    } lcbs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_range;
        logic stop;
        logic slot_free;
    } lcbs_status_t;

endpackage

// ===== rtl/core/lcbs_div.sv =====
// ----------------------------------------------------------------------------
// lcbs_div - iterative unsigned divider, 32-bit dividend by 8-bit divisor
// Restoring division, two quotient bits per cycle; done pulses for one
// cycle when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module lcbs_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lcbs_pkg::LBA_W-1:0]  dividend,
    input  logic [lcbs_pkg::DIV_W-1:0]  divisor,
    output logic                        done,
    output logic [lcbs_pkg::LBA_W-1:0]  quotient,
    output logic [lcbs_pkg::DIV_W-1:0]  remainder
);
    import lcbs_pkg::*;

    logic [DIV_W-1:0]     rem_reg,  rem_next;
    logic [LBA_W-1:0]     quo_reg,  quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // two restoring steps per cycle
    always_comb begin
        logic [DIV_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
            trial    = {rem_next, quo_next[LBA_W-1]};
            quo_next = {quo_next[LBA_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_next    = DIV_W'(trial - {1'b0, divisor});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
        end
    end

    // control: step counter and done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial remainder and shifting quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/lcbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcbs_ctrl - burst sequencer controller
// Runs the two divisions, checks the range and steps the emission of one
// CHS word per cycle while the output register has room.
// ----------------------------------------------------------------------------
module lcbs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   count_zero,
    output logic                   s_ready,
    input  lcbs_pkg::lcbs_status_t status,
    output lcbs_pkg::lcbs_cmd_t    cmd
);
    import lcbs_pkg::*;

    lcbs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                // a zero count is taken and dropped
                if (s_valid && !count_zero) state_next = ST_START;
            end
            ST_START:     state_next = ST_WAIT_SECT;
            ST_WAIT_SECT: if (status.div_done) state_next = ST_WAIT_HEAD;
            ST_WAIT_HEAD: begin
                if (status.div_done) state_next = status.out_range ? ST_OOR : ST_EMIT;
            end
            ST_EMIT: begin
                if (status.slot_free && status.stop) state_next = ST_IDLE;
            end
            ST_OOR:  if (status.slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_START: begin
                cmd.div_start = 1'b1;
            end
            ST_WAIT_SECT: begin
                // divisor stays on sectors until the first pass is done,
                // then the quotient is fed back for the second pass
                cmd.div_sel    = status.div_done;
                cmd.div_start  = status.div_done;
                cmd.latch_sect = status.div_done;
            end
            ST_WAIT_HEAD: begin
                cmd.div_sel   = 1'b1;
                cmd.latch_chs = status.div_done && !status.out_range;
            end
            ST_EMIT:  cmd.emit     = status.slot_free;
            ST_OOR:   cmd.emit_oor = status.slot_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/lcbs_datapath.sv =====
// ----------------------------------------------------------------------------
// lcbs_datapath - geometry registers, divider, position counters, output word
// Holds the configuration, converts the start address through the shared
// divider and walks sector, head and cylinder for each emitted word.
// ----------------------------------------------------------------------------
module lcbs_datapath #(
    parameter int MAX_BURST = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lcbs_pkg::IDX_W-1:0]    cfg_index,
    input  logic [lcbs_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic [lcbs_pkg::LBA_W-1:0]    s_start_block,
    input  logic [lcbs_pkg::COUNT_W-1:0]  s_sector_count,
    output logic                          count_zero,
    input  lcbs_pkg::lcbs_cmd_t           cmd,
    output lcbs_pkg::lcbs_status_t        status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lcbs_pkg::CYL_W-1:0]    m_cylinder,
    output logic [lcbs_pkg::HEAD_W-1:0]   m_head,
    output logic [lcbs_pkg::SECT_W-1:0]   m_sector,
    output logic [lcbs_pkg::DRIVE_W-1:0]  m_drive,
    output logic                          m_out_of_range,
    output logic                          m_last
);
    import lcbs_pkg::*;

    localparam logic [COUNT_W-1:0] BURST_MAX = COUNT_W'(MAX_BURST);

    // configuration
    logic [SECT_W-1:0]  spt_reg;
    logic [HEAD_W-1:0]  hpc_reg;
    logic [CYL_W-1:0]   lcyl_reg;
    logic [DRIVE_W-1:0] drive_reg;

    // working registers
    logic [LBA_W-1:0]   start_reg;
    logic [COUNT_W-1:0] remaining_reg;
    logic [CYL_W-1:0]   cyl_reg;
    logic [HEAD_W-1:0]  head_reg;
    logic [SECT_W-1:0]  sect_reg;

    // output word
    logic               m_valid_reg;
    logic [CYL_W-1:0]   m_cyl_reg;
    logic [HEAD_W-1:0]  m_head_reg;
    logic [SECT_W-1:0]  m_sect_reg;
    logic [DRIVE_W-1:0] m_drive_reg;
    logic               m_oor_reg;
    logic               m_last_reg;

    logic [SECT_W-1:0]  spt_eff;
    logic [HEAD_W-1:0]  hpc_eff;
    logic [LBA_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_done;
    logic [LBA_W-1:0]   div_quotient;
    logic [DIV_W-1:0]   div_remainder;
    logic               sect_more;
    logic               head_more;
    logic               cyl_more;
    logic               disk_end;

    // zero geometry counts as one
    assign spt_eff = (spt_reg == '0) ? SECT_W'(1) : spt_reg;
    assign hpc_eff = (hpc_reg == '0) ? HEAD_W'(1) : hpc_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg   <= SPT_RESET;
            hpc_reg   <= HPC_RESET;
            lcyl_reg  <= LCYL_RESET;
            drive_reg <= DRIVE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_SECTORS_PER_TRACK:  spt_reg   <= cfg_wr_data[SECT_W-1:0];
                REG_HEADS_PER_CYLINDER: hpc_reg   <= cfg_wr_data[HEAD_W-1:0];
                REG_LAST_CYLINDER:      lcyl_reg  <= cfg_wr_data[CYL_W-1:0];
                REG_DRIVE_NUMBER:       drive_reg <= cfg_wr_data[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // first pass: start / sectors, second pass: that quotient / heads
    assign div_dividend = cmd.div_sel ? div_quotient : start_reg;
    assign div_divisor  = cmd.div_sel ? hpc_eff : DIV_W'(spt_eff);

    lcbs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // step conditions for the position counters
    assign sect_more = sect_reg < spt_eff;
    assign head_more = ({1'b0, head_reg} + 1'b1) < {1'b0, hpc_eff};
    assign cyl_more  = cyl_reg < lcyl_reg;
    assign disk_end  = !sect_more && !head_more && !cyl_more;

    // input capture and position walk
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            start_reg     <= s_start_block;
            remaining_reg <= (s_sector_count > BURST_MAX) ? BURST_MAX : s_sector_count;
        end
        if (cmd.latch_sect) begin
            sect_reg <= div_remainder[SECT_W-1:0] + 1'b1;
        end
        if (cmd.latch_chs) begin
            cyl_reg  <= div_quotient[CYL_W-1:0];
            head_reg <= div_remainder;
        end
        if (cmd.emit) begin
            remaining_reg <= remaining_reg - 1'b1;
            if (sect_more) begin
                sect_reg <= sect_reg + 1'b1;
            end else if (head_more) begin
                head_reg <= head_reg + 1'b1;
                sect_reg <= SECT_W'(1);
            end else if (cyl_more) begin
                cyl_reg  <= cyl_reg + 1'b1;
                head_reg <= '0;
                sect_reg <= SECT_W'(1);
            end
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.emit_oor) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_cyl_reg   <= cyl_reg;
            m_head_reg  <= head_reg;
            m_sect_reg  <= sect_reg;
            m_drive_reg <= drive_reg;
            m_oor_reg   <= 1'b0;
            m_last_reg  <= status.stop;
        end else if (cmd.emit_oor) begin
            m_cyl_reg   <= '0;
            m_head_reg  <= '0;
            m_sect_reg  <= '0;
            m_drive_reg <= drive_reg;
            m_oor_reg   <= 1'b1;
            m_last_reg  <= 1'b1;
        end
    end

    // status back to the controller
    assign count_zero       = (s_sector_count == '0);
    assign status.div_done  = div_done;
    assign status.out_range = div_quotient > LBA_W'(lcyl_reg);
    assign status.stop      = (remaining_reg == COUNT_W'(1)) || disk_end;
    assign status.slot_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_cylinder     = m_cyl_reg;
    assign m_head         = m_head_reg;
    assign m_sector       = m_sect_reg;
    assign m_drive        = m_drive_reg;
    assign m_out_of_range = m_oor_reg;
    assign m_last         = m_last_reg;

endmodule

// ===== rtl/core/lba_to_chs_burst_sequencer.sv =====
// ----------------------------------------------------------------------------
// lba_to_chs_burst_sequencer - LBA to CHS conversion with burst expansion
// Converts a start block to cylinder, head and sector with the programmed
// geometry and emits one CHS word per requested sector, up to the disk end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready) takes one request word: a start block and
//   a sector count (saturated to MAX_BURST). The result channel
//   (m_valid/m_ready) gives one CHS word per sector, m_last on the final one.
//   The burst ends early at the last sector of the disk. A count of zero
//   is taken and produces nothing. A start beyond the last cylinder
//   produces a single word with m_out_of_range and m_last set. Geometry
//   and drive number are written through cfg_wr_en/cfg_index/cfg_wr_data;
//   the user must write them only while the block is idle, which the block
//   itself does not enforce. The shared divider retires two quotient bits
//   a cycle over two 32-bit divisions; after that one word leaves per cycle
//   while the receiver takes them; s_ready is low until the burst ends.
//   When the receiver stalls the current word holds in the output register
//   and the sector walk pauses until it is taken.
//   Reset (aresetn, synchronous, active low) loads the default geometry of
//   18 sectors, 2 heads, last cylinder 79, drive 0, and empties the output.
// ----------------------------------------------------------------------------
module lba_to_chs_burst_sequencer #(
    parameter int MAX_BURST = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [lcbs_pkg::IDX_W-1:0]    cfg_index,
    input  logic [lcbs_pkg::CFG_W-1:0]    cfg_wr_data,
    // request
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lcbs_pkg::LBA_W-1:0]    s_start_block,
    input  logic [lcbs_pkg::COUNT_W-1:0]  s_sector_count,
    // results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lcbs_pkg::CYL_W-1:0]    m_cylinder,
    output logic [lcbs_pkg::HEAD_W-1:0]   m_head,
    output logic [lcbs_pkg::SECT_W-1:0]   m_sector,
    output logic [lcbs_pkg::DRIVE_W-1:0]  m_drive,
    output logic                          m_out_of_range,
    output logic                          m_last
);
    import lcbs_pkg::*;

    lcbs_cmd_t    cmd;
    lcbs_status_t status;
    logic         count_zero;

    lcbs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .count_zero (count_zero),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    lcbs_datapath #(
        .MAX_BURST (MAX_BURST)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_start_block  (s_start_block),
        .s_sector_count (s_sector_count),
        .count_zero     (count_zero),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cylinder     (m_cylinder),
        .m_head         (m_head),
        .m_sector       (m_sector),
        .m_drive        (m_drive),
        .m_out_of_range (m_out_of_range),
        .m_last         (m_last)
    );

endmodule
